### rtl/core/sldf_pkg.sv
// Package for the sync, length and checksum deframer.
// Holds widths, status and phase codes, the result type and defaults.
// No dependencies.
package sldf_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W = 16;
    localparam int SUM_W = 16;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 1;

    localparam int DEFAULT_MAX_PAYLOAD = 256;

    localparam logic [BYTE_W-1:0] TYPE_INVALID = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_SYNC  = 3'd1,
        ST_LONG  = 3'd2,
        ST_TRUNC = 3'd3,
        ST_CKSUM = 3'd4
    } status_t;

    typedef enum logic [7:0] {
        PH_SYNC1   = 8'b0000_0001,
        PH_SYNC2   = 8'b0000_0010,
        PH_TYPE    = 8'b0000_0100,
        PH_LENHI   = 8'b0000_1000,
        PH_LENLO   = 8'b0001_0000,
        PH_PAYLOAD = 8'b0010_0000,
        PH_CKHI    = 8'b0100_0000,
        PH_CKLO    = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic              result_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] packet_type;
        status_t           frame_status;
    } result_t;

endpackage

### rtl/core/sldf_in_if.sv
// Input channel of the deframer: one received byte per word.
// Depends on sldf_pkg.
interface sldf_in_if
    import sldf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/core/sldf_out_if.sv
// Output channel of the deframer: one payload byte or frame status per word.
// Depends on sldf_pkg.
interface sldf_out_if
    import sldf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                result_kind;
    logic [BYTE_W-1:0]   payload_byte;
    logic [BYTE_W-1:0]   packet_type;
    logic [STATUS_W-1:0] frame_status;

    modport source (output valid, output result_kind, output payload_byte,
                    output packet_type, output frame_status, input ready);
    modport sink (input valid, input result_kind, input payload_byte,
                  input packet_type, input frame_status, output ready);
endinterface

### rtl/core/sync_length_checksum_deframer.sv
// Top level of the sync, length and checksum deframer.
// Depends on sldf_pkg, sldf_in_if, sldf_out_if and sldf_fsm.
//
// The rx channel carries one received byte per word, with last_byte set on
// the final byte of each buffer. The tx channel carries one word per payload
// byte (result_kind 0) and one frame status per buffer (result_kind 1), whose
// packet_type is the frame type when the status is ok and 0xff otherwise.
// Bytes that produce no result give no tx word.
// The sync bytes are set through the write port: index 0 is the first sync
// byte and index 1 the second. They should be written only while idle.
// An accepted byte is held in the input register, parsed as it moves on, and its
// result is registered and offered on tx. One byte is accepted in every cycle
// while tx is not stalled; the rate is set by the single parse stage, whose
// longest path is the 16-bit running sum and the length compare.
// Reset clears both sync registers to zero, empties the input and output
// registers and leaves the parser waiting for the first sync byte.
// When the receiver stalls, the result stays on tx and one further byte can
// be taken into the input register; rx.ready then drops until tx moves.
module sync_length_checksum_deframer
    import sldf_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sldf_in_if.sink              rx,
    sldf_out_if.source           tx,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    logic [BYTE_W-1:0] sync_first_reg;
    logic [BYTE_W-1:0] sync_second_reg;

    logic              s0_valid_reg, s0_valid_next;
    logic [BYTE_W-1:0] s0_data_reg;
    logic              s0_last_reg;

    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg;

    logic              advance;
    logic              rx_fire;
    logic              out_load;
    logic              fsm_res_valid;
    result_t           fsm_res;

    assign advance  = s0_valid_reg && (!out_valid_reg || tx.ready);
    assign rx.ready = !s0_valid_reg || advance;
    assign rx_fire  = rx.valid && rx.ready;
    assign out_load = !out_valid_reg || tx.ready;

    always_comb
    begin
        s0_valid_next = s0_valid_reg;
        if (rx_fire)
        begin
            s0_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s0_valid_next = 1'b0;
        end
        out_valid_next = out_load ? fsm_res_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= '0;
            sync_second_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default:         sync_first_reg  <= sync_first_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= s0_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            s0_data_reg <= rx.data_byte;
            s0_last_reg <= rx.last_byte;
        end
        if (out_load && fsm_res_valid)
        begin
            out_res_reg <= fsm_res;
        end
    end

    sldf_fsm #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_en     (advance),
        .data_byte   (s0_data_reg),
        .last_byte   (s0_last_reg),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .res_valid   (fsm_res_valid),
        .res         (fsm_res)
    );

    assign tx.valid        = out_valid_reg;
    assign tx.result_kind  = out_res_reg.result_kind;
    assign tx.payload_byte = out_res_reg.payload_byte;
    assign tx.packet_type  = out_res_reg.packet_type;
    assign tx.frame_status = out_res_reg.frame_status;

    // A payload word carries no type or status.
    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && !tx.result_kind |-> tx.packet_type == '0 && tx.frame_status == ST_OK)
        else $error("payload word with type or status set");

    // A failed frame always reports the invalid type.
    a_fail_type: assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && tx.result_kind && tx.frame_status != ST_OK
        |-> tx.packet_type == TYPE_INVALID)
        else $error("failed frame without invalid type");

    // A status word never carries payload data.
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && tx.result_kind |-> tx.payload_byte == '0)
        else $error("status word with payload data");

    // The input side only stalls behind a result that is waiting on tx.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> out_valid_reg && !tx.ready && s0_valid_reg)
        else $error("input stalled without a waiting result");

endmodule

### rtl/core/sldf_fsm.sv
// Frame parser of the deframer: phase, length, count and running sum.
// Works on one byte per enabled cycle and forms its result combinationally.
// Depends on sldf_pkg.
module sldf_fsm
    import sldf_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_en,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              last_byte,
    input  logic [BYTE_W-1:0] sync_first,
    input  logic [BYTE_W-1:0] sync_second,
    output logic              res_valid,
    output result_t           res
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    phase_t             phase_reg, phase_next;
    logic               status_given_reg, status_given_next;
    logic [BYTE_W-1:0]  held_type_reg, held_type_next;
    logic [LEN_W-1:0]   frame_length_reg, frame_length_next;
    logic [CNT_W-1:0]   bytes_seen_reg, bytes_seen_next;
    logic [SUM_W-1:0]   running_sum_reg, running_sum_next;
    logic [BYTE_W-1:0]  checksum_high_reg, checksum_high_next;

    logic               stat_emit;
    logic               pay_emit;
    status_t            code;
    logic [LEN_W-1:0]   len_full;

    always_comb
    begin
        phase_next         = phase_reg;
        status_given_next  = status_given_reg;
        held_type_next     = held_type_reg;
        frame_length_next  = frame_length_reg;
        bytes_seen_next    = bytes_seen_reg;
        running_sum_next   = running_sum_reg;
        checksum_high_next = checksum_high_reg;
        stat_emit          = 1'b0;
        pay_emit           = 1'b0;
        code               = ST_OK;
        len_full           = {frame_length_reg[LEN_W-1:BYTE_W], data_byte};

        if (!status_given_reg)
        begin
            unique case (phase_reg)
                PH_SYNC1:
                begin
                    if (data_byte != sync_first)
                    begin
                        stat_emit = 1'b1;
                        code      = ST_SYNC;
                    end
                    else
                    begin
                        phase_next = PH_SYNC2;
                    end
                end
                PH_SYNC2:
                begin
                    if (data_byte != sync_second)
                    begin
                        stat_emit = 1'b1;
                        code      = ST_SYNC;
                    end
                    else
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    held_type_next = data_byte;
                    phase_next     = PH_LENHI;
                end
                PH_LENHI:
                begin
                    frame_length_next = {data_byte, {BYTE_W{1'b0}}};
                    phase_next        = PH_LENLO;
                end
                PH_LENLO:
                begin
                    frame_length_next = len_full;
                    bytes_seen_next   = '0;
                    running_sum_next  = '0;
                    if (len_full > MAX_LEN)
                    begin
                        stat_emit = 1'b1;
                        code      = ST_LONG;
                    end
                    else if (len_full == '0)
                    begin
                        phase_next = PH_CKHI;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    running_sum_next = running_sum_reg + SUM_W'(data_byte);
                    bytes_seen_next  = bytes_seen_reg + CNT_W'(1);
                    if (LEN_W'(bytes_seen_next) >= frame_length_reg)
                    begin
                        phase_next = PH_CKHI;
                    end
                    pay_emit = !last_byte;
                end
                PH_CKHI:
                begin
                    checksum_high_next = data_byte;
                    phase_next         = PH_CKLO;
                end
                PH_CKLO:
                begin
                    stat_emit = 1'b1;
                    code = ({checksum_high_reg, data_byte} == running_sum_reg) ?
                           ST_OK : ST_CKSUM;
                end
                default:
                begin
                    phase_next = PH_SYNC1;
                end
            endcase

            if (last_byte && !stat_emit)
            begin
                stat_emit = 1'b1;
                pay_emit  = 1'b0;
                code      = ST_TRUNC;
            end
        end

        if (last_byte)
        begin
            phase_next        = PH_SYNC1;
            status_given_next = 1'b0;
        end
        else
        begin
            status_given_next = status_given_reg | stat_emit;
        end
    end

    assign res_valid = item_en && (stat_emit || pay_emit);

    always_comb
    begin
        res.result_kind  = stat_emit;
        res.payload_byte = pay_emit ? data_byte : '0;
        res.packet_type  = '0;
        res.frame_status = ST_OK;
        if (stat_emit)
        begin
            res.packet_type  = (code == ST_OK) ? held_type_reg : TYPE_INVALID;
            res.frame_status = code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SYNC1;
            status_given_reg <= 1'b0;
        end
        else if (item_en)
        begin
            phase_reg        <= phase_next;
            status_given_reg <= status_given_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_en)
        begin
            held_type_reg     <= held_type_next;
            frame_length_reg  <= frame_length_next;
            bytes_seen_reg    <= bytes_seen_next;
            running_sum_reg   <= running_sum_next;
            checksum_high_reg <= checksum_high_next;
        end
    end

endmodule

### sim/deframe_checker.sv
// Checker for the sync, length and checksum deframer: watches both channels
// and the write port, predicts every tx word and compares it with what comes.
// Depends on sldf_pkg, sldf_in_if and sldf_out_if.
`timescale 1ns / 100ps

module deframe_checker
    import sldf_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sldf_in_if                   rx,
    sldf_out_if                  tx,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    output int                   mismatch_count,
    output int                   words_outstanding,
    output int                   payload_words,
    output int                   status_words
);

    logic [BYTE_W-1:0] sync_a;
    logic [BYTE_W-1:0] sync_b;

    phase_t            phase;
    logic [BYTE_W-1:0] held_type;
    logic [LEN_W-1:0]  frame_len;
    logic [8:0]        seen_count;
    logic [SUM_W-1:0]  sum_acc;
    logic [BYTE_W-1:0] check_high;
    logic              status_given;

    result_t           expected_q[$];
    result_t           want;

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic push_status(input status_t code);
        result_t w;
        w.result_kind  = 1'b1;
        w.payload_byte = '0;
        w.packet_type  = (code == ST_OK) ? held_type : TYPE_INVALID;
        w.frame_status = code;
        expected_q = {expected_q, w};
        status_given = 1'b1;
    endtask

    task automatic deframe_byte(input logic [BYTE_W-1:0] b, input logic fin);
        result_t w;
        if (!status_given)
        begin
            case (phase)
                PH_SYNC1:
                    if (b != sync_a)
                        push_status(ST_SYNC);
                    else
                        phase = PH_SYNC2;
                PH_SYNC2:
                    if (b != sync_b)
                        push_status(ST_SYNC);
                    else
                        phase = PH_TYPE;
                PH_TYPE:
                begin
                    held_type = b;
                    phase = PH_LENHI;
                end
                PH_LENHI:
                begin
                    frame_len = {b, 8'h00};
                    phase = PH_LENLO;
                end
                PH_LENLO:
                begin
                    frame_len = {frame_len[15:8], b};
                    seen_count = '0;
                    sum_acc = '0;
                    if (frame_len > MAX_PAYLOAD)
                        push_status(ST_LONG);
                    else
                        phase = (frame_len == 0) ? PH_CKHI : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    sum_acc = sum_acc + b;
                    seen_count = seen_count + 1'b1;
                    if ({7'b0, seen_count} >= frame_len)
                        phase = PH_CKHI;
                    if (!fin)
                    begin
                        w.result_kind  = 1'b0;
                        w.payload_byte = b;
                        w.packet_type  = '0;
                        w.frame_status = ST_OK;
                        expected_q = {expected_q, w};
                    end
                end
                PH_CKHI:
                begin
                    check_high = b;
                    phase = PH_CKLO;
                end
                default:
                    if ({check_high, b} == sum_acc)
                        push_status(ST_OK);
                    else
                        push_status(ST_CKSUM);
            endcase
            if (fin && !status_given)
                push_status(ST_TRUNC);
        end
        if (fin)
        begin
            phase = PH_SYNC1;
            status_given = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_a = '0;
            sync_b = '0;
            phase = PH_SYNC1;
            held_type = '0;
            frame_len = '0;
            seen_count = '0;
            sum_acc = '0;
            check_high = '0;
            status_given = 1'b0;
            expected_q.delete();
            mismatch_count = 0;
            payload_words = 0;
            status_words = 0;
            words_outstanding <= 0;
        end
        else
        begin
            if (tx.valid && tx.ready)
            begin
                if (expected_q.size() == 0)
                    note_failure($sformatf({"unexpected word: kind=%0d byte=%02h ",
                                            "type=%02h status=%0d"},
                                           tx.result_kind, tx.payload_byte, tx.packet_type,
                                           tx.frame_status));
                else
                begin
                    want = expected_q.pop_front();
                    if (tx.result_kind !== want.result_kind
                        || tx.payload_byte !== want.payload_byte
                        || tx.packet_type !== want.packet_type
                        || tx.frame_status !== want.frame_status)
                        note_failure($sformatf({"mismatch: expected kind=%0d byte=%02h type=%02h ",
                                                "status=%0d, got kind=%0d byte=%02h type=%02h ",
                                                "status=%0d"},
                                               want.result_kind, want.payload_byte,
                                               want.packet_type, want.frame_status,
                                               tx.result_kind, tx.payload_byte,
                                               tx.packet_type, tx.frame_status));
                    else if (want.result_kind)
                        status_words++;
                    else
                        payload_words++;
                end
            end
            if (rx.valid && rx.ready)
                deframe_byte(rx.data_byte, rx.last_byte);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SYNC_FIRST:  sync_a = cfg_data;
                    CFG_SYNC_SECOND: sync_b = cfg_data;
                    default:         ;
                endcase
            end
            words_outstanding <= expected_q.size();
        end
    end

endmodule

### sim/testbench.sv
// Top of the deframer testbench: clock, reset, byte stimulus, receiver
// back-pressure and the verdict. Depends on sldf_pkg, both channel
// interfaces, the deframer and deframe_checker.
`timescale 1ns / 100ps

module testbench;
    import sldf_pkg::*;

    localparam int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    int                   sender_idle_pct = 8;
    int                   receiver_idle_pct = 67;
    logic                 long_hold_armed = 1'b0;
    logic                 long_hold_done = 1'b0;
    int                   hold_left = 0;
    int                   bytes_sent = 0;
    logic [BYTE_W-1:0]    sync_a_now = '0;
    logic [BYTE_W-1:0]    sync_b_now = '0;

    int                   mismatch_count;
    int                   words_outstanding;
    int                   payload_words;
    int                   status_words;

    sldf_in_if  rx_if ();
    sldf_out_if tx_if ();

    sync_length_checksum_deframer #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_if),
        .tx        (tx_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    deframe_checker #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .rx                (rx_if),
        .tx                (tx_if),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatch_count    (mismatch_count),
        .words_outstanding (words_outstanding),
        .payload_words     (payload_words),
        .status_words      (status_words)
    );

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        tx_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                tx_if.ready <= 1'b0;
            else if (long_hold_armed && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                hold_left = 400;
                tx_if.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left--;
                tx_if.ready <= 1'b0;
            end
            else
                tx_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.data_byte <= b;
        rx_if.last_byte <= fin;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_buffer(input logic [BYTE_W-1:0] bytes_in[$]);
        foreach (bytes_in[i])
            send_byte(bytes_in[i], i == bytes_in.size() - 1);
    endtask

    task automatic drain();
        int n;
        n = 0;
        rx_if.valid <= 1'b0;
        @(posedge clk);
        while (words_outstanding != 0 && n < 5000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_syncs(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_SYNC_FIRST;
        cfg_data <= a;
        @(posedge clk);
        cfg_index <= CFG_SYNC_SECOND;
        cfg_data <= b;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        sync_a_now = a;
        sync_b_now = b;
    endtask

    task automatic send_random_buffer();
        logic [BYTE_W-1:0] frame_q[$];
        logic [BYTE_W-1:0] pick;
        logic [SUM_W-1:0]  sum;
        int                kind;
        int                len;
        int                idx;
        int                cut;
        kind = $urandom_range(99);
        frame_q = {sync_a_now, sync_b_now, 8'($urandom_range(255))};
        if (kind < 8)
        begin
            len = $urandom_range(65535, MAX_PAYLOAD + 1);
            frame_q = {frame_q, len[15:8]};
            frame_q = {frame_q, len[7:0]};
            repeat ($urandom_range(3)) frame_q = {frame_q, 8'($urandom_range(255))};
        end
        else if (kind < 13)
        begin
            idx = $urandom_range(1);
            frame_q[idx] = frame_q[idx] ^ 8'($urandom_range(255, 1));
            repeat ($urandom_range(3)) frame_q = {frame_q, 8'($urandom_range(255))};
        end
        else if (kind < 18)
        begin
            frame_q.delete();
            repeat ($urandom_range(6, 1)) frame_q = {frame_q, 8'($urandom_range(255))};
        end
        else
        begin
            if ($urandom_range(39) == 0)
                len = MAX_PAYLOAD;
            else if ($urandom_range(14) == 0)
                len = $urandom_range(MAX_PAYLOAD);
            else
                len = $urandom_range(12);
            frame_q = {frame_q, len[15:8]};
            frame_q = {frame_q, len[7:0]};
            sum = '0;
            repeat (len)
            begin
                pick = 8'($urandom_range(255));
                sum = sum + pick;
                frame_q = {frame_q, pick};
            end
            if ($urandom_range(9) == 0)
                sum = sum ^ 16'($urandom_range(65535, 1));
            frame_q = {frame_q, sum[15:8]};
            frame_q = {frame_q, sum[7:0]};
            if (kind < 32)
            begin
                cut = $urandom_range(frame_q.size() - 1, 1);
                while (frame_q.size() > cut)
                    void'(frame_q.pop_back());
            end
            else if (kind < 47)
                repeat ($urandom_range(4, 1)) frame_q = {frame_q, 8'($urandom_range(255))};
        end
        send_buffer(frame_q);
    endtask

    task automatic run_random(input int upto);
        while (bytes_sent < upto)
            send_random_buffer();
    endtask

    initial
    begin
        logic [BYTE_W-1:0] directed[$];
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_SYNC_FIRST;
        cfg_data <= '0;
        rx_if.valid <= 1'b0;
        rx_if.data_byte <= '0;
        rx_if.last_byte <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sync bytes are still at their reset value of zero here.
        directed = {8'h00, 8'h00, 8'h3C, 8'h00, 8'h01, 8'hFF, 8'h00, 8'hFF};
        send_buffer(directed);
        directed = {8'h5A};
        send_buffer(directed);
        directed = {8'h00, 8'h01};
        send_buffer(directed);
        directed = {8'h00, 8'h00, 8'h81, 8'hFF, 8'hFF};
        send_buffer(directed);
        directed = {8'h00, 8'h00, 8'h02, 8'h00, 8'h03, 8'hFF};
        send_buffer(directed);
        directed = {8'h00, 8'h00, 8'hC3, 8'h00, 8'h00, 8'hFF, 8'hFF};
        send_buffer(directed);

        write_syncs(8'hFF, 8'h00);
        run_random(560);

        write_syncs(8'hA5, 8'h5A);
        sender_idle_pct = 67;
        receiver_idle_pct = 8;
        run_random(1080);

        write_syncs(8'h00, 8'hFF);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        long_hold_armed = 1'b1;
        run_random(1300);
        drain();
        run_random(1620);
        drain();
        repeat (8) @(posedge clk);

        $display({"Sent %0d bytes under four sync settings; checked %0d payload words ",
                  "and %0d frame statuses."},
                 bytes_sent, payload_words, status_words);
        if (words_outstanding != 0)
            $display("%0d expected words never arrived.", words_outstanding);
        if (mismatch_count == 0 && words_outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/core/sldf_pkg.sv
rtl/core/sldf_in_if.sv
rtl/core/sldf_out_if.sv
rtl/core/sldf_fsm.sv
rtl/core/sync_length_checksum_deframer.sv
sim/deframe_checker.sv
sim/testbench.sv
